@@ src/apsp_pkg.sv @@
// Package for the angular point projection: constants, register indexes and CORDIC angle table.
package apsp_pkg;

    localparam int APSP_ANGLE_BITS    = 16;
    localparam int APSP_CORDIC_STAGES = 16;
    localparam int APSP_TAB_LEN       = 24;

    // CORDIC gain in Q16, applied to dz so both axes of the elevation CORDIC match
    localparam logic signed [18:0] APSP_GAIN_Q16 = 19'sd107922;

    localparam int APSP_CFG_AW = 4;

    localparam logic [APSP_CFG_AW-1:0] CFG_VIEWER_X      = 4'd0;
    localparam logic [APSP_CFG_AW-1:0] CFG_VIEWER_Y      = 4'd1;
    localparam logic [APSP_CFG_AW-1:0] CFG_VIEWER_Z      = 4'd2;
    localparam logic [APSP_CFG_AW-1:0] CFG_VIEW_HEADING  = 4'd3;
    localparam logic [APSP_CFG_AW-1:0] CFG_VIEW_PITCH    = 4'd4;
    localparam logic [APSP_CFG_AW-1:0] CFG_HALF_FOV      = 4'd5;
    localparam logic [APSP_CFG_AW-1:0] CFG_SCREEN_WIDTH  = 4'd6;
    localparam logic [APSP_CFG_AW-1:0] CFG_SCREEN_HEIGHT = 4'd7;

    // atan(2^-i), 2^32 units per full turn
    function automatic logic [31:0] atan32(input int i);
        logic [31:0] v;
        unique case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // table entry rounded to ab bits per full turn
    function automatic int atan_step(input int i, input int ab);
        logic [63:0] t;
        t = {32'd0, atan32(i)};
        t = (t + (64'd1 << (31 - ab))) >> (32 - ab);
        return int'(t[31:0]);
    endfunction

endpackage

@@ src/angular_point_to_screen_projection.sv @@
// Top level: pipelined angular projection of a Q16.16 point to saturated screen pixels.
// Throughput: one point per cycle; two vectoring CORDICs in series, one stage per
//   iteration, then two 32-stage restoring dividers (one quotient bit per stage).
// The whole pipeline advances together; it holds while a result waits and the sink is stalled.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
// The configuration port is always ready; each write is registered and lands in the next cycle.
module angular_point_to_screen_projection
    import apsp_pkg::*;
#(
    parameter int ANGLE_BITS    = APSP_ANGLE_BITS,
    parameter int CORDIC_STAGES = APSP_CORDIC_STAGES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [APSP_CFG_AW-1:0] i_cfg_addr,
    input  logic [31:0]            i_cfg_data,
    // point input
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [31:0]     i_point_x,
    input  logic signed [31:0]     i_point_y,
    input  logic signed [31:0]     i_point_z,
    // result output
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [15:0]     o_screen_x,
    output logic signed [15:0]     o_screen_y,
    output logic                   o_saturated
);

    localparam int N    = CORDIC_STAGES;
    localparam int CW   = 38;               // CORDIC datapath, covers gain growth
    localparam int ZW   = ANGLE_BITS + 2;   // angle accumulator, beyond a half turn
    localparam int BW   = ZW + 17;          // angle to 16-bit binary angle conversion
    localparam int VW   = 19;               // elevation minus pitch
    localparam int DW   = 32;               // divider numerator / quotient
    localparam int RW   = 15;               // divisor width
    localparam int NSTG = 2 * N + 39;

    localparam logic signed [ZW-1:0] QUARTER  = ZW'(1) <<< (ANGLE_BITS - 2);
    localparam logic signed [BW-1:0] BAM_RND  = BW'(1) <<< (ANGLE_BITS - 1);

    // ---------------- configuration registers ----------------
    logic signed [31:0] r_viewer_x, r_viewer_y, r_viewer_z;
    logic [15:0]        r_heading;
    logic signed [15:0] r_pitch;
    logic [14:0]        r_half_fov;
    logic [12:0]        r_width, r_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_viewer_x <= '0;
            r_viewer_y <= '0;
            r_viewer_z <= 32'sd65536;
            r_heading  <= '0;
            r_pitch    <= '0;
            r_half_fov <= 15'd4096;
            r_width    <= 13'd800;
            r_height   <= 13'd600;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_VIEWER_X:      r_viewer_x <= i_cfg_data;
                CFG_VIEWER_Y:      r_viewer_y <= i_cfg_data;
                CFG_VIEWER_Z:      r_viewer_z <= i_cfg_data;
                CFG_VIEW_HEADING:  r_heading  <= i_cfg_data[15:0];
                CFG_VIEW_PITCH:    r_pitch    <= i_cfg_data[15:0];
                CFG_HALF_FOV:      r_half_fov <= i_cfg_data[14:0];
                CFG_SCREEN_WIDTH:  r_width    <= i_cfg_data[12:0];
                CFG_SCREEN_HEIGHT: r_height   <= i_cfg_data[12:0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // Derived config; the user must keep it stable while points are in flight (not enforced here)
    logic [RW-1:0] fov;
    logic [11:0]   hw, hh;
    assign fov = (r_half_fov == '0) ? RW'(1) : r_half_fov;
    assign hw  = r_width[12:1];
    assign hh  = r_height[12:1];

    // ---------------- pipeline control ----------------
    logic            en;
    logic [NSTG-1:0] r_vld;

    assign en      = !r_vld[NSTG-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // ---------------- stage 0: offsets from viewer ----------------
    logic signed [32:0] r_dx, r_dy, r_dz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx <= 33'(i_point_x) - 33'(r_viewer_x);
            r_dy <= 33'(i_point_y) - 33'(r_viewer_y);
            r_dz <= 33'(i_point_z) - 33'(r_viewer_z);
        end
    end

    // ---------------- stage 1: pre-rotation, dz gain ----------------
    logic signed [CW-1:0] r_ax [0:N];
    logic signed [CW-1:0] r_ay [0:N];
    logic signed [ZW-1:0] r_az [0:N];
    logic signed [CW-1:0] r_dzk [0:N];
    logic                 r_azero [0:N];

    logic signed [CW-1:0] pr_x, pr_y;
    logic signed [ZW-1:0] pr_z;
    logic signed [50:0]   dz_prod;

    always_comb begin
        pr_x = CW'(r_dx);
        pr_y = CW'(r_dy);
        pr_z = '0;
        if (r_dx < 0) begin
            if (r_dy >= 0) begin
                pr_x = CW'(r_dy);
                pr_y = -CW'(r_dx);
                pr_z = QUARTER;
            end else begin
                pr_x = -CW'(r_dy);
                pr_y = CW'(r_dx);
                pr_z = -QUARTER;
            end
        end
        dz_prod = r_dz * APSP_GAIN_Q16;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax[0]    <= pr_x;
            r_ay[0]    <= pr_y;
            r_az[0]    <= pr_z;
            r_dzk[0]   <= CW'($signed(dz_prod[50:16]));
            r_azero[0] <= (r_dx == '0) && (r_dy == '0);
        end
    end

    // ---------------- azimuth CORDIC, one iteration per stage ----------------
    for (genvar k = 0; k < N; k++) begin : g_az
        localparam logic signed [ZW-1:0] STEP = ZW'(atan_step(k, ANGLE_BITS));
        logic signed [CW-1:0] xs, ys;
        assign xs = r_ax[k] >>> k;
        assign ys = r_ay[k] >>> k;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_ay[k] > 0) begin
                    r_ax[k+1] <= r_ax[k] + ys;
                    r_ay[k+1] <= r_ay[k] - xs;
                    r_az[k+1] <= r_az[k] + STEP;
                end else begin
                    r_ax[k+1] <= r_ax[k] - ys;
                    r_ay[k+1] <= r_ay[k] + xs;
                    r_az[k+1] <= r_az[k] - STEP;
                end
                r_dzk[k+1]   <= r_dzk[k];
                r_azero[k+1] <= r_azero[k];
            end
        end
    end

    // ---------------- elevation CORDIC: (magnitude, gained dz) ----------------
    logic signed [CW-1:0] r_ex [0:N];
    logic signed [CW-1:0] r_ey [0:N];
    logic signed [ZW-1:0] r_ez [0:N];
    logic signed [ZW-1:0] r_azc [0:N];
    logic                 r_ezero [0:N];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ex[0]    <= r_ax[N];
            r_ey[0]    <= r_dzk[N];
            r_ez[0]    <= '0;
            r_azc[0]   <= r_azero[N] ? '0 : r_az[N];
            r_ezero[0] <= (r_ax[N] == '0) && (r_dzk[N] == '0);
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_el
        localparam logic signed [ZW-1:0] STEP = ZW'(atan_step(k, ANGLE_BITS));
        logic signed [CW-1:0] xs, ys;
        assign xs = r_ex[k] >>> k;
        assign ys = r_ey[k] >>> k;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_ey[k] > 0) begin
                    r_ex[k+1] <= r_ex[k] + ys;
                    r_ey[k+1] <= r_ey[k] - xs;
                    r_ez[k+1] <= r_ez[k] + STEP;
                end else begin
                    r_ex[k+1] <= r_ex[k] - ys;
                    r_ey[k+1] <= r_ey[k] + xs;
                    r_ez[k+1] <= r_ez[k] - STEP;
                end
                r_azc[k+1]   <= r_azc[k];
                r_ezero[k+1] <= r_ezero[k];
            end
        end
    end

    // ---------------- stage A: binary angles, offsets from view ----------------
    logic signed [ZW-1:0] el_a;
    logic signed [BW-1:0] az_bam, el_bam;
    logic [15:0]          hd_u;
    logic signed [15:0]   r_hd;
    logic signed [VW-1:0] r_vd;

    assign el_a   = r_ezero[N] ? '0 : r_ez[N];
    assign az_bam = ((BW'(r_azc[N]) <<< 16) + BAM_RND) >>> ANGLE_BITS;
    assign el_bam = ((BW'(el_a) <<< 16) + BAM_RND) >>> ANGLE_BITS;
    assign hd_u   = az_bam[15:0] - r_heading;   // wraps to a half turn

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hd <= $signed(hd_u);
            r_vd <= VW'($signed(el_bam[17:0])) - VW'(r_pitch);
        end
    end

    // ---------------- stage B: scale by half screen ----------------
    logic signed [31:0] r_px, r_py;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px <= $signed({1'b0, hw}) * r_hd;
            r_py <= $signed({1'b0, hh}) * r_vd;
        end
    end

    // ---------------- stage C: magnitude plus half divisor ----------------
    logic [DW-1:0] r_numx [0:DW];
    logic [DW-1:0] r_numy [0:DW];
    logic [DW-1:0] r_qx   [0:DW];
    logic [DW-1:0] r_qy   [0:DW];
    logic [RW-1:0] r_remx [0:DW];
    logic [RW-1:0] r_remy [0:DW];
    logic          r_negx [0:DW];
    logic          r_negy [0:DW];

    logic [DW-1:0] mx, my;
    assign mx = r_px[31] ? DW'(-r_px) : DW'(r_px);
    assign my = r_py[31] ? DW'(-r_py) : DW'(r_py);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_numx[0] <= mx + DW'(fov >> 1);
            r_numy[0] <= my + DW'(fov >> 1);
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            r_remx[0] <= '0;
            r_remy[0] <= '0;
            r_negx[0] <= r_px[31];
            r_negy[0] <= r_py[31];
        end
    end

    // ---------------- restoring dividers, one quotient bit per stage ----------------
    for (genvar j = 0; j < DW; j++) begin : g_div
        logic [RW:0] tx, ty;
        logic        gx, gy;
        assign tx = {r_remx[j], r_numx[j][DW-1]};
        assign ty = {r_remy[j], r_numy[j][DW-1]};
        assign gx = tx >= {1'b0, fov};
        assign gy = ty >= {1'b0, fov};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_remx[j+1] <= gx ? RW'(tx - {1'b0, fov}) : RW'(tx);
                r_remy[j+1] <= gy ? RW'(ty - {1'b0, fov}) : RW'(ty);
                r_numx[j+1] <= r_numx[j] << 1;
                r_numy[j+1] <= r_numy[j] << 1;
                r_qx[j+1]   <= {r_qx[j][DW-2:0], gx};
                r_qy[j+1]   <= {r_qy[j][DW-2:0], gy};
                r_negx[j+1] <= r_negx[j];
                r_negy[j+1] <= r_negy[j];
            end
        end
    end

    // ---------------- output: centre offset and saturation ----------------
    logic signed [DW+1:0] qsx, qsy, sx, sy;
    logic                 hix, lox, hiy, loy;

    assign qsx = r_negx[DW] ? -(DW+2)'(r_qx[DW]) : (DW+2)'(r_qx[DW]);
    assign qsy = r_negy[DW] ? -(DW+2)'(r_qy[DW]) : (DW+2)'(r_qy[DW]);
    assign sx  = (DW+2)'(hw) - qsx;
    assign sy  = (DW+2)'(hh) - qsy;
    assign hix = sx > 32767;
    assign lox = sx < -32768;
    assign hiy = sy > 32767;
    assign loy = sy < -32768;

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_screen_x  <= hix ? 16'sh7fff : (lox ? 16'sh8000 : sx[15:0]);
            o_screen_y  <= hiy ? 16'sh7fff : (loy ? 16'sh8000 : sy[15:0]);
            o_saturated <= hix || lox || hiy || loy;
        end
    end

    // ---------------- assertions ----------------
    a_in_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted point did not enter the pipeline");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_screen_x) && $stable(o_screen_y)
            && $stable(o_saturated))
        else $error("stalled result changed");

    a_sat_clamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_screen_x == 16'sh7fff || o_screen_x == 16'sh8000
            || o_screen_y == 16'sh7fff || o_screen_y == 16'sh8000)
        else $error("saturation flag without a clamped pixel");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("point accepted while the pipeline is held");

endmodule

@@ tb/angular_point_to_screen_projection_chk.sv @@
// Checker for the angular projection: tracks registers, predicts pixels and compares results.
module angular_point_to_screen_projection_chk
    import apsp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [APSP_CFG_AW-1:0] i_cfg_addr,
    input  logic [31:0]            i_cfg_data,
    input  logic                   i_valid,
    input  logic                   i_ready,
    input  logic signed [31:0]     i_point_x,
    input  logic signed [31:0]     i_point_y,
    input  logic signed [31:0]     i_point_z,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic signed [15:0]     i_screen_x,
    input  logic signed [15:0]     i_screen_y,
    input  logic                   i_saturated,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               sat;
    } t_pixel;

    // atan(2^-i), 2^32 per full turn
    localparam longint ARC_TURN32 [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };
    localparam int     AB        = APSP_ANGLE_BITS;
    localparam longint GAIN_Q16  = 107922;

    t_pixel expected_pixels[$];

    logic [31:0] viewer_x, viewer_y, viewer_z;
    logic [15:0] heading, pitch;
    logic [14:0] half_fov;
    logic [12:0] width, height;

    function automatic longint arc_step(input int i);
        return (ARC_TURN32[i] + (longint'(1) << (31 - AB))) >>> (32 - AB);
    endfunction

    // vectoring rotation: angle in 2^AB units per turn, magnitude scaled by gain
    function automatic longint vector_angle(input longint x_in, input longint y_in,
                                            output longint mag);
        longint x, y, z, t, xs, ys;
        x = x_in;
        y = y_in;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = longint'(1) << (AB - 2);
            end else begin
                x = -y; y = t; z = -(longint'(1) << (AB - 2));
            end
        end
        for (int i = 0; i < APSP_CORDIC_STAGES && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + arc_step(i);
            end else begin
                x = x - ys; y = y + xs; z = z - arc_step(i);
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic longint div_nearest(input longint n, input longint d);
        longint m, q;
        m = (n < 0) ? -n : n;
        q = (m + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint clamp16(input longint v, inout logic flag);
        if (v > 32767) begin
            flag = 1'b1; return 32767;
        end
        if (v < -32768) begin
            flag = 1'b1; return -32768;
        end
        return v;
    endfunction

    function automatic t_pixel project_point(input logic signed [31:0] px,
                                             input logic signed [31:0] py,
                                             input logic signed [31:0] pz);
        longint dx, dy, dz, az, el, mag, unused, dzk, az16, el16, hd, vd, fov, hw, hh;
        logic [15:0] u;
        logic        flag;
        t_pixel      r;
        dx = longint'(px) - longint'($signed(viewer_x));
        dy = longint'(py) - longint'($signed(viewer_y));
        dz = longint'(pz) - longint'($signed(viewer_z));
        az = 0; el = 0; mag = 0; flag = 1'b0;
        if (dx != 0 || dy != 0) az = vector_angle(dx, dy, mag);
        dzk = (dz * GAIN_Q16) >>> 16;
        if (mag != 0 || dzk != 0) el = vector_angle(mag, dzk, unused);
        az16 = (az * 65536 + (longint'(1) << (AB - 1))) >>> AB;
        el16 = (el * 65536 + (longint'(1) << (AB - 1))) >>> AB;
        u  = az16[15:0] - heading;
        hd = longint'($signed(u));
        vd = el16 - longint'($signed(pitch));
        fov = (half_fov == 0) ? 1 : longint'(half_fov);
        hw = longint'(width >> 1);
        hh = longint'(height >> 1);
        r.sx  = 16'(clamp16(hw - div_nearest(hw * hd, fov), flag));
        r.sy  = 16'(clamp16(hh - div_nearest(hh * vd, fov), flag));
        r.sat = flag;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pixel e;
        if (!i_rst_n) begin
            expected_pixels.delete();
            viewer_x <= 32'd0; viewer_y <= 32'd0; viewer_z <= 32'd65536;
            heading  <= 16'd0; pitch    <= 16'd0; half_fov <= 15'd4096;
            width    <= 13'd800; height <= 13'd600;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_addr)
                    CFG_VIEWER_X:      viewer_x <= i_cfg_data;
                    CFG_VIEWER_Y:      viewer_y <= i_cfg_data;
                    CFG_VIEWER_Z:      viewer_z <= i_cfg_data;
                    CFG_VIEW_HEADING:  heading  <= i_cfg_data[15:0];
                    CFG_VIEW_PITCH:    pitch    <= i_cfg_data[15:0];
                    CFG_HALF_FOV:      half_fov <= i_cfg_data[14:0];
                    CFG_SCREEN_WIDTH:  width    <= i_cfg_data[12:0];
                    CFG_SCREEN_HEIGHT: height   <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_valid && i_ready)
                expected_pixels = {expected_pixels,
                                   project_point(i_point_x, i_point_y, i_point_z)};
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d sat=%0b", $time,
                             i_screen_x, i_screen_y, i_saturated);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_pixels.pop_front();
                    if (e.sx !== i_screen_x || e.sy !== i_screen_y || e.sat !== i_saturated) begin
                        $display("%0t: mismatch expected x=%0d y=%0d sat=%0b actual x=%0d y=%0d sat=%0b",
                                 $time, e.sx, e.sy, e.sat, i_screen_x, i_screen_y, i_saturated);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_pixels.size();
    end

    initial o_fail_count = 0;

endmodule

@@ tb/angular_point_to_screen_projection_tb.sv @@
// Testbench top: stimulus, handshake pacing and verdict for the angular projection.
module angular_point_to_screen_projection_tb;
    import apsp_pkg::*;

    localparam int LATENCY    = 2 * APSP_CORDIC_STAGES + 39;
    localparam int STALL_LIM  = 5000;   // cycles without any transaction
    localparam int N_PHASES   = 8;
    localparam int PER_PHASE  = 135;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [APSP_CFG_AW-1:0] i_cfg_addr;
    logic [31:0]            i_cfg_data;
    logic                   i_valid;
    logic                   o_ready;
    logic signed [31:0]     i_point_x, i_point_y, i_point_z;
    logic                   o_valid;
    logic                   i_ready;
    logic signed [15:0]     o_screen_x, o_screen_y;
    logic                   o_saturated;

    int fail_count;
    int pending;
    int points_sent;
    int quiet_cycles;

    // shadow of the viewer position, used to aim points near it
    logic [31:0] aim_x, aim_y, aim_z;

    angular_point_to_screen_projection dut (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_addr, .i_cfg_data,
        .i_valid, .o_ready, .i_point_x, .i_point_y, .i_point_z,
        .o_valid, .i_ready, .o_screen_x, .o_screen_y, .o_saturated
    );

    angular_point_to_screen_projection_chk chk (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_addr, .i_cfg_data,
        .i_valid, .i_ready(o_ready), .i_point_x, .i_point_y, .i_point_z,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_screen_x(o_screen_x), .i_screen_y(o_screen_y), .i_saturated(o_saturated),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: any transaction on any channel restarts the count
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIM) begin
            $display("watchdog expired at %0t", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random back-pressure, one long hold-off mid-stream, one stretch always ready
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && points_sent >= 300) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;            // long hold-off, fills the pipeline
            end else if (points_sent >= 600 && points_sent < 850)
                i_ready <= 1'b1;
            else
                i_ready <= ($urandom_range(99) >= 27);
        end
    end

    // one register write transaction; valid lowered afterwards
    task automatic write_reg(input logic [APSP_CFG_AW-1:0] idx, input logic [31:0] val);
        logic ok;
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering points, then wait until the pipeline has drained
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // one point transaction; gap taken before it so valid is never dropped while a point waits
    task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        logic ok;
        int   gap;
        gap = 0;
        if (!(points_sent >= 400 && points_sent < 600) && $urandom_range(99) < 15)
            gap = $urandom_range(4, 1);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        do begin
            @(negedge i_clk);
            ok = o_ready;
            @(posedge i_clk);
        end while (!ok);
        points_sent++;
    endtask

    function automatic logic [31:0] near(input logic [31:0] c);
        case ($urandom_range(5))
            0, 1:    return $urandom;
            2:       return c + 32'($signed($urandom_range(16, 0)) - 8);
            3:       return c;
            default: return c + {{12{1'($urandom_range(1))}}, 20'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] pick_edge32();
        case ($urandom_range(4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic set_view(input logic [31:0] vx, input logic [31:0] vy,
                            input logic [31:0] vz, input logic [15:0] hd,
                            input logic [15:0] pt, input logic [31:0] fov,
                            input logic [31:0] w, input logic [31:0] h);
        write_reg(CFG_VIEWER_X, vx);
        write_reg(CFG_VIEWER_Y, vy);
        write_reg(CFG_VIEWER_Z, vz);
        write_reg(CFG_VIEW_HEADING, {16'($urandom), hd});
        write_reg(CFG_VIEW_PITCH, {16'($urandom), pt});
        write_reg(CFG_HALF_FOV, fov);
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
        // unused index: must not disturb anything
        write_reg(4'(8 + $urandom_range(7)), $urandom);
        aim_x = vx; aim_y = vy; aim_z = vz;
    endtask

    initial begin
        logic [15:0] pt;
        logic [31:0] fov, w, h;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_point_x   <= '0;
        i_point_y   <= '0;
        i_point_z   <= '0;
        points_sent = 0;
        aim_x = 0; aim_y = 0; aim_z = 32'd65536;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed points under reset registers
        send_point(32'd0, 32'd0, 32'd65536);            // coincident with viewer
        send_point(32'd0, 32'd0, 32'h7FFF_FFFF);        // straight above
        send_point(32'd0, 32'd0, 32'h8000_0000);        // straight below
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'd0, 32'd65536);    // behind, on the x axis
        send_point(32'h8000_0000, 32'd1, 32'd65536);
        send_point(32'h8000_0000, 32'hFFFF_FFFF, 32'd65536);
        send_point(32'd0, 32'h7FFF_FFFF, 32'd0);
        send_point(32'd0, 32'h8000_0000, 32'd0);
        send_point(32'd65536, 32'd0, 32'd65536);
        send_point(32'd65536, 32'd6554, 32'd72090);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

        // directed extremes of the registers
        wait_drained();
        set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'h8000,
                 32'd0, 32'd1, 32'd0);                 // zero fov, odd and zero screen
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'd0, 32'd0, 32'd0);
        wait_drained();
        set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4096);  // fov above a quarter turn
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'd0, 32'd0, 32'd0);

        // random phases, each with its own view
        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            case (p % 4)
                0:       pt = 16'($signed($urandom_range(32768)) - 16384);
                1:       pt = 16'sd16384;
                2:       pt = -16'sd16384;
                default: pt = 16'($urandom);
            endcase
            case ($urandom_range(4))
                0:       fov = 32'd1;
                1:       fov = 32'd16384;
                2:       fov = $urandom;
                default: fov = $urandom_range(16384, 1);
            endcase
            case ($urandom_range(4))
                0:       w = 32'd4096;
                1:       w = $urandom;
                default: w = $urandom_range(4096, 1);
            endcase
            case ($urandom_range(4))
                0:       h = 32'd4096;
                1:       h = $urandom;
                default: h = $urandom_range(4096, 1);
            endcase
            set_view(pick_edge32(), pick_edge32(), pick_edge32(), 16'($urandom), pt, fov, w, h);
            for (int k = 0; k < PER_PHASE; k++)
                send_point(near(aim_x), near(aim_y), near(aim_z));
        end

        wait_drained();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
